// File: hw/rtl/multilevel_priority_fifo_scheduler_macros.svh
// assertion macros for the scheduler
`ifndef MULTILEVEL_PRIORITY_FIFO_SCHEDULER_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_SCHEDULER_MACROS_SVH

// checked at every rising edge, quiet while reset is held
`define MPFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form, antecedent and consequent in the same cycle
`define MPFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mpfs_pkg.sv
package mpfs_pkg;

    localparam int NUM_LEVELS  = 4;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int SLICE_BASE  = 4;

    localparam int LVL_W   = 2;
    localparam int PID_W   = 8;
    localparam int SLICE_W = 3;
    localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W  = LVL_W + PTR_W;
    localparam int RAM_DEPTH = NUM_LEVELS << PTR_W;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // what stage one carries towards the output register
    typedef struct packed {
        logic               is_next;
        logic               accepted;
        logic               granted;
        logic [SLICE_W-1:0] time_slice;
        logic               any_waiting;
    } result_meta_t;

endpackage

// File: hw/rtl/mpfs_ram.sv
module mpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/multilevel_priority_fifo_scheduler.sv
// Four-level priority FIFO scheduler. An add transfer (operation 0) appends
// process_id to the FIFO of level priority_req, or reports accepted 0 when
// that level already holds LEVEL_DEPTH entries. A next transfer (operation 1)
// removes the head of the lowest-numbered non-empty level and returns it with
// a time slice of 4 minus that level, or granted 0 when every level is empty.
// Every result reports any_waiting, whether any level still holds a process.
// One transfer is taken every cycle unless out_ready holds back the results;
// each result passes through stage one, holding the registered read of the shared
// entry RAM (4 x LEVEL_DEPTH identifiers, one port written, one read), then the
// output register. Results come back in order, one per input transfer.
`include "multilevel_priority_fifo_scheduler_macros.svh"

module multilevel_priority_fifo_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [mpfs_pkg::PID_W-1:0]  process_id,
    input  logic [mpfs_pkg::LVL_W-1:0]  priority_req,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        accepted,
    output logic                        granted,
    output logic [mpfs_pkg::PID_W-1:0]  granted_id,
    output logic [mpfs_pkg::SLICE_W-1:0] time_slice,
    output logic                        any_waiting
);

    // per level occupancy and ring pointers
    mpfs_pkg::cnt_t cnt_reg  [mpfs_pkg::NUM_LEVELS];
    mpfs_pkg::cnt_t cnt_next [mpfs_pkg::NUM_LEVELS];
    mpfs_pkg::ptr_t head_reg  [mpfs_pkg::NUM_LEVELS];
    mpfs_pkg::ptr_t head_next [mpfs_pkg::NUM_LEVELS];
    mpfs_pkg::ptr_t tail_reg  [mpfs_pkg::NUM_LEVELS];
    mpfs_pkg::ptr_t tail_next [mpfs_pkg::NUM_LEVELS];

    // stage one: decision taken, waiting for the ram read data
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    mpfs_pkg::result_meta_t s1_meta_reg;
    mpfs_pkg::result_meta_t s1_meta_next;

    // output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           accepted_reg;
    logic                           accepted_next;
    logic                           granted_reg;
    logic                           granted_next;
    logic [mpfs_pkg::PID_W-1:0]     granted_id_reg;
    logic [mpfs_pkg::PID_W-1:0]     granted_id_next;
    logic [mpfs_pkg::SLICE_W-1:0]   time_slice_reg;
    logic [mpfs_pkg::SLICE_W-1:0]   time_slice_next;
    logic                           any_waiting_reg;
    logic                           any_waiting_next;

    // entry ram
    logic                           ram_we;
    logic                           ram_re;
    logic [mpfs_pkg::ADDR_W-1:0]    ram_waddr;
    logic [mpfs_pkg::ADDR_W-1:0]    ram_raddr;
    logic [mpfs_pkg::ID_BITS-1:0]   ram_wdata;
    logic [mpfs_pkg::ID_BITS-1:0]   ram_rdata;

    logic                           in_xfer;
    logic                           s1_adv;
    logic                           sel_found;
    logic [mpfs_pkg::LVL_W-1:0]     sel_lvl;
    logic [31:0]                    pid_wide;
    logic [31:0]                    rdata_wide;

    mpfs_ram #(
        .WIDTH (mpfs_pkg::ID_BITS),
        .DEPTH (mpfs_pkg::RAM_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // stage one moves on when the output register is empty or being drained
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = in_valid && in_ready;

    // identifiers are kept to ID_BITS bits in the store, 8 bits on the way out
    assign pid_wide   = 32'(process_id);
    assign ram_wdata  = pid_wide[mpfs_pkg::ID_BITS-1:0];
    assign rdata_wide = 32'(ram_rdata);

    // fixed priority pick: lowest-numbered level with something queued
    always_comb
    begin
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int lv = mpfs_pkg::NUM_LEVELS - 1; lv >= 0; lv--)
        begin
            if (cnt_reg[lv] != '0)
            begin
                sel_found = 1'b1;
                sel_lvl   = mpfs_pkg::LVL_W'(lv);
            end
        end
    end

    // queue bookkeeping for the transfer taken this cycle
    always_comb
    begin
        for (int lv = 0; lv < mpfs_pkg::NUM_LEVELS; lv++)
        begin
            cnt_next[lv]  = cnt_reg[lv];
            head_next[lv] = head_reg[lv];
            tail_next[lv] = tail_reg[lv];
        end
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = {priority_req, tail_reg[priority_req]};
        ram_raddr    = {sel_lvl, head_reg[sel_lvl]};
        s1_meta_next = '0;

        if (in_xfer)
        begin
            case (operation)
                mpfs_pkg::OP_ADD:
                begin
                    // refused when the level is full
                    if (cnt_reg[priority_req] != mpfs_pkg::CNT_W'(mpfs_pkg::LEVEL_DEPTH))
                    begin
                        ram_we = 1'b1;
                        if (tail_reg[priority_req]
                            == mpfs_pkg::PTR_W'(mpfs_pkg::LEVEL_DEPTH - 1))
                        begin
                            tail_next[priority_req] = '0;
                        end
                        else
                        begin
                            tail_next[priority_req] = tail_reg[priority_req] + 1'b1;
                        end
                        cnt_next[priority_req] = cnt_reg[priority_req] + 1'b1;
                        s1_meta_next.accepted  = 1'b1;
                    end
                end
                mpfs_pkg::OP_NEXT:
                begin
                    s1_meta_next.is_next = 1'b1;
                    if (sel_found)
                    begin
                        ram_re = 1'b1;
                        if (head_reg[sel_lvl]
                            == mpfs_pkg::PTR_W'(mpfs_pkg::LEVEL_DEPTH - 1))
                        begin
                            head_next[sel_lvl] = '0;
                        end
                        else
                        begin
                            head_next[sel_lvl] = head_reg[sel_lvl] + 1'b1;
                        end
                        cnt_next[sel_lvl]       = cnt_reg[sel_lvl] - 1'b1;
                        s1_meta_next.granted    = 1'b1;
                        s1_meta_next.time_slice = mpfs_pkg::SLICE_W'(mpfs_pkg::SLICE_BASE)
                                                  - mpfs_pkg::SLICE_W'(sel_lvl);
                    end
                end
                default:
                begin
                    s1_meta_next = '0;
                end
            endcase
        end

        // occupancy after this step
        for (int lv = 0; lv < mpfs_pkg::NUM_LEVELS; lv++)
        begin
            if (cnt_next[lv] != '0)
            begin
                s1_meta_next.any_waiting = 1'b1;
            end
        end
    end

    // pipeline advance
    always_comb
    begin
        if (in_ready)
        begin
            s1_valid_next = in_xfer;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        out_valid_next   = out_valid_reg;
        accepted_next    = accepted_reg;
        granted_next     = granted_reg;
        granted_id_next  = granted_id_reg;
        time_slice_next  = time_slice_reg;
        any_waiting_next = any_waiting_reg;

        if (s1_adv)
        begin
            out_valid_next   = s1_valid_reg;
            accepted_next    = s1_meta_reg.accepted;
            granted_next     = s1_meta_reg.granted;
            time_slice_next  = s1_meta_reg.time_slice;
            any_waiting_next = s1_meta_reg.any_waiting;
            // ram data belongs to this item only when it was granted
            if (s1_meta_reg.granted)
            begin
                granted_id_next = rdata_wide[mpfs_pkg::PID_W-1:0];
            end
            else
            begin
                granted_id_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int lv = 0; lv < mpfs_pkg::NUM_LEVELS; lv++)
            begin
                cnt_reg[lv]  <= '0;
                head_reg[lv] <= '0;
                tail_reg[lv] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int lv = 0; lv < mpfs_pkg::NUM_LEVELS; lv++)
            begin
                cnt_reg[lv]  <= cnt_next[lv];
                head_reg[lv] <= head_next[lv];
                tail_reg[lv] <= tail_next[lv];
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_meta_reg <= s1_meta_next;
        end
        accepted_reg    <= accepted_next;
        granted_reg     <= granted_next;
        granted_id_reg  <= granted_id_next;
        time_slice_reg  <= time_slice_next;
        any_waiting_reg <= any_waiting_next;
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign granted     = granted_reg;
    assign granted_id  = granted_id_reg;
    assign time_slice  = time_slice_reg;
    assign any_waiting = any_waiting_reg;

    // an item never both stores and grants
    `MPFS_ASSERT_IMP(a_excl_result, s1_valid_reg, !(s1_meta_reg.accepted && s1_meta_reg.granted), "add and grant in one result")

    // a grant always carries a non-zero quantum
    `MPFS_ASSERT_IMP(a_grant_slice, s1_valid_reg && s1_meta_reg.granted, s1_meta_reg.time_slice != '0, "grant without time slice")

    // a refused next means every level was empty, so nothing can still wait
    `MPFS_ASSERT_IMP(a_empty_next, s1_valid_reg && s1_meta_reg.is_next && !s1_meta_reg.granted, !s1_meta_reg.any_waiting, "empty next reports waiting process")

    // level occupancy stays within the ring
    `MPFS_ASSERT(a_cnt_bound, (cnt_reg[0] <= mpfs_pkg::CNT_W'(mpfs_pkg::LEVEL_DEPTH)) && (cnt_reg[1] <= mpfs_pkg::CNT_W'(mpfs_pkg::LEVEL_DEPTH)) && (cnt_reg[2] <= mpfs_pkg::CNT_W'(mpfs_pkg::LEVEL_DEPTH)) && (cnt_reg[3] <= mpfs_pkg::CNT_W'(mpfs_pkg::LEVEL_DEPTH)), "level count beyond depth")

endmodule
